@@ hdl/crc_rs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rs_pkg
// shared widths, register indexes, reset values and types of the serial crc
// ----------------------------------------------------------------------------
package crc_rs_pkg;

    localparam int REM_W          = 32;
    localparam int DEG_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_DEGREE_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY_COEFFS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MODE  = 2'd2;

    localparam logic [REM_W-1:0] POLY_RESET   = 32'd7;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd8;
    localparam logic             CHECK_RESET  = 1'b0;

    typedef struct packed {
        logic [REM_W-1:0] poly;
        logic [REM_W-1:0] mask;
        logic [REM_W-1:0] top_bit;
        logic             check;
    } cfg_t;

    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic             remainder_nonzero;
    } res_t;

endpackage
`default_nettype wire

@@ hdl/crc_rs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rs_if
// valid/ready channels for message bits and remainder words
// ----------------------------------------------------------------------------
interface crc_rs_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic last;

    modport source (output valid, output data_bit, output last, input ready);
    modport sink   (input valid, input data_bit, input last, output ready);
endinterface

interface crc_rs_out_if;
    import crc_rs_pkg::*;
    logic             valid;
    logic             ready;
    logic [REM_W-1:0] remainder;
    logic             remainder_nonzero;

    modport source (output valid, output remainder, output remainder_nonzero, input ready);
    modport sink   (input valid, input remainder, input remainder_nonzero, output ready);
endinterface
`default_nettype wire

@@ hdl/crc_remainder_serial.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_remainder_serial
// bit-serial crc remainder with a programmable generator polynomial
// ----------------------------------------------------------------------------
// in_ch carries one message bit per word, most significant first, with last
// set on the final bit. out_ch carries one word per message: the remainder in
// the low degree bits and a nonzero flag. the config port writes poly_coeffs,
// degree and check_mode by index; write it only while the block is idle.
// every bit is taken into an input register and folded into the running
// remainder from there, so one bit per cycle is sustained while no last bit
// waits for the output register. the result word of a last bit is loaded
// into the output register, which holds it until the receiver takes it.
// while a result waits, later non-last bits keep flowing; a second last bit
// waits in the input register until the receiver takes the first result.
// reset clears the running remainder, both valid flags and restores the
// default generator (degree 8, coefficients 7, generate mode).
// ----------------------------------------------------------------------------
module crc_remainder_serial #(
    parameter int MAX_DEGREE = crc_rs_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [crc_rs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crc_rs_pkg::REM_W-1:0]     cfg_data,
    crc_rs_in_if.sink                             in_ch,
    crc_rs_out_if.source                          out_ch
);
    import crc_rs_pkg::*;

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic res_free;

    crc_rs_cfg #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc_rs_core #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    crc_rs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .out_ch    (out_ch)
    );

endmodule
`default_nettype wire

@@ hdl/crc_rs_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rs_cfg
// configuration registers and the derived generator mask and top-bit select
// ----------------------------------------------------------------------------
module crc_rs_cfg #(
    parameter int MAX_DEGREE = crc_rs_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [crc_rs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crc_rs_pkg::REM_W-1:0]     cfg_data,
    output crc_rs_pkg::cfg_t                      cfg
);
    import crc_rs_pkg::*;

    localparam int CAP = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    logic [REM_W-1:0] poly_reg;
    logic [DEG_W-1:0] degree_reg;
    logic             check_reg;

    logic [DEG_W-1:0] eff_degree;
    logic [REM_W:0]   pow;
    logic [REM_W:0]   pow_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            degree_reg <= DEGREE_RESET;
            check_reg  <= CHECK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLY_COEFFS: poly_reg   <= cfg_data;
                CFG_DEGREE:      degree_reg <= cfg_data[DEG_W-1:0];
                CFG_CHECK_MODE:  check_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // degree clamped to 1..CAP
    always_comb
    begin
        eff_degree = degree_reg;
        if (eff_degree == '0)
            eff_degree = DEG_W'(1);
        if (eff_degree > DEG_W'(CAP))
            eff_degree = DEG_W'(CAP);
    end

    assign pow    = (REM_W+1)'(1) << eff_degree;
    assign pow_m1 = pow - (REM_W+1)'(1);

    assign cfg.mask    = pow_m1[REM_W-1:0];
    assign cfg.top_bit = pow[REM_W:1];
    assign cfg.poly    = poly_reg & pow_m1[REM_W-1:0];
    assign cfg.check   = check_reg;

endmodule
`default_nettype wire

@@ hdl/crc_rs_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rs_core
// input register, running remainder and the one-bit shift-and-xor step
// ----------------------------------------------------------------------------
module crc_rs_core #(
    parameter int MAX_DEGREE = crc_rs_pkg::MAX_DEGREE_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    crc_rs_in_if.sink         in_ch,
    input  crc_rs_pkg::cfg_t  cfg,
    input  wire logic         res_free,
    output logic              res_valid,
    output crc_rs_pkg::res_t  res
);
    import crc_rs_pkg::*;

    localparam int CAP = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;

    logic           s1_valid_reg;
    logic           s1_bit_reg;
    logic           s1_last_reg;
    logic [CAP-1:0] rem_reg;
    logic [CAP-1:0] rem_next;

    logic [CAP-1:0] mask;
    logic [CAP-1:0] r;
    logic [CAP:0]   shifted;
    logic           top;
    logic           fb;
    logic           s1_fire;

    assign mask = cfg.mask[CAP-1:0];
    assign r    = rem_reg & mask;
    assign top  = |(r & cfg.top_bit[CAP-1:0]);

    always_comb
    begin
        if (cfg.check)
        begin
            shifted = {r, s1_bit_reg};
            fb      = top;
        end
        else
        begin
            shifted = {r, 1'b0};
            fb      = top ^ s1_bit_reg;
        end
        rem_next = shifted[CAP-1:0] & mask;
        if (fb)
            rem_next = rem_next ^ cfg.poly[CAP-1:0];
    end

    // a last bit needs a free output slot, other bits never wait
    assign s1_fire     = s1_valid_reg && (!s1_last_reg || res_free);
    assign in_ch.ready = !s1_valid_reg || s1_fire;

    assign res_valid             = s1_fire && s1_last_reg;
    assign res.remainder         = REM_W'(rem_next);
    assign res.remainder_nonzero = |rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (s1_fire)
                rem_reg <= s1_last_reg ? '0 : rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_bit_reg  <= in_ch.data_bit;
            s1_last_reg <= in_ch.last;
        end
    end

endmodule
`default_nettype wire

@@ hdl/crc_rs_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crc_rs_out
// result register that holds a remainder word until the receiver takes it
// ----------------------------------------------------------------------------
module crc_rs_out (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         res_valid,
    input  crc_rs_pkg::res_t  res,
    output logic              res_free,
    crc_rs_out_if.source      out_ch
);
    import crc_rs_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign res_free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_free)
            valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
            res_reg <= res;
    end

    assign out_ch.valid             = valid_reg;
    assign out_ch.remainder         = res_reg.remainder;
    assign out_ch.remainder_nonzero = res_reg.remainder_nonzero;

endmodule
`default_nettype wire
